// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/core/uvs_pkg.sv
// Types, constants and helpers of the UV sphere vertex generator
package uvs_pkg;
   localparam int FRAC_BITS = 25;
   localparam int QUOT_W    = FRAC_BITS + 1;
   localparam int PHASE_W   = 24;
   localparam int SINE_LAT  = 8;
   localparam int TEX_DLY   = SINE_LAT + 1;
   localparam int PIPE_LAT  = FRAC_BITS + SINE_LAT + 2;

   typedef logic [30:0] q30_type;

   typedef struct packed {
      q30_type mag;
      logic    neg;
   } sine_type;

   localparam q30_type Q30_ONE  = 31'h4000_0000;
   localparam q30_type SC11     = 31'd3864;
   localparam q30_type HORNER_COEF [5] = '{31'd172272, 31'd5026995, 31'd85569306,
                                           31'd693598668, 31'd1686629713};

   localparam logic [1:0] REG_RING    = 2'd0;
   localparam logic [1:0] REG_SEGMENT = 2'd1;
   localparam logic [1:0] REG_RADIUS  = 2'd2;
   localparam logic [1:0] REG_SPARE   = 2'd3;

   function automatic logic [15:0] to_q15(input logic neg, input q30_type mag);
      logic [31:0] sum;
      logic [16:0] r;
      sum = {1'b0, mag} + 32'h0000_4000;
      r   = sum[31:15];
      if (neg) begin
         if (r > 17'd32768) r = 17'd32768;
         to_q15 = 16'(17'd0 - r);
      end else begin
         if (r > 17'd32767) r = 17'd32767;
         to_q15 = r[15:0];
      end
   endfunction
endpackage

// File: rtl/core/uv_sphere_vertex_generator.sv
// Top level: UV sphere vertex generator with APB-style register port
//  channel | dir | handshake           | payload
//  req     | in  | req_valid/req_ready | ring_index, segment_index
//  rsp     | out | rsp_valid/rsp_ready | pos, tex, norm, tan
//  csr     | in  | psel/penable/pready | paddr, pwdata, prdata
// One vertex per cycle while rsp is not held; rsp_valid rises when the req reaches the end of the valid pipeline.
// Pipeline: 25 divider cells per axis, 8-stage sine pipeline, product and output stage.
// Reset clears the valid pipeline and loads ring 16, segment 32, radius 1.0.
// A held rsp freezes every stage; req_ready drops in the same cycle.
`include "assert_macros.svh"
module uv_sphere_vertex_generator #(
   parameter int GRID_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [GRID_BITS-1:0]  req_ring_index,
   input  logic [GRID_BITS-1:0]  req_segment_index,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic signed [16:0]    rsp_pos_x,
   output logic signed [16:0]    rsp_pos_y,
   output logic signed [16:0]    rsp_pos_z,
   output logic [16:0]           rsp_tex_u,
   output logic [16:0]           rsp_tex_v,
   output logic signed [15:0]    rsp_norm_x,
   output logic signed [15:0]    rsp_norm_y,
   output logic signed [15:0]    rsp_norm_z,
   output logic signed [15:0]    rsp_tan_x,
   output logic signed [15:0]    rsp_tan_z,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [3:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);
   localparam int QW = uvs_pkg::QUOT_W;
   localparam int NC = uvs_pkg::FRAC_BITS;

   logic [GRID_BITS-1:0] ring_cnt_ff, ring_cnt_in;
   logic [GRID_BITS-1:0] seg_cnt_ff, seg_cnt_in;
   logic [15:0]          radius_ff, radius_in;
   logic                 wr_en;

   logic [GRID_BITS-1:0] rings, segs, ring_c, seg_c;
   logic [GRID_BITS-1:0] rrem [NC+1];
   logic [QW-1:0]        rquot [NC+1];
   logic [GRID_BITS-1:0] srem [NC+1];
   logic [QW-1:0]        squot [NC+1];

   logic [uvs_pkg::PIPE_LAT-1:0] vld_ff, vld_in;
   logic                         adv;

   logic [QW:0]                    s_sum;
   logic [QW-1:0]                  r_sum;
   logic [18:0]                    u_sum, v_sum;
   logic [uvs_pkg::PHASE_W-1:0]    theta, phi, theta_c, phi_c;
   logic [16:0]                    tex_u, tex_v;
   logic [16:0]                    texu_ff [uvs_pkg::TEX_DLY];
   logic [16:0]                    texv_ff [uvs_pkg::TEX_DLY];

   uvs_pkg::sine_type sp, cp, st, ct;
   logic [61:0]       nx_prod, nz_prod;
   uvs_pkg::q30_type  nx_ff, nz_ff;
   logic              nxn_ff, nzn_ff;
   uvs_pkg::sine_type cp_ff, st_ff, ct_ff;

   logic [16:0] px_in, py_in, pz_in;
   logic [16:0] px_ff, py_ff, pz_ff, tu_ff, tv_ff;
   logic [15:0] nxq_ff, nyq_ff, nzq_ff, tx_ff, tz_ff;

   function automatic logic [16:0] to_pos(input logic neg, input uvs_pkg::q30_type mag,
                                          input logic [15:0] rad);
      logic [47:0] prod;
      logic [17:0] r;
      prod = ({17'd0, mag} * {32'd0, rad}) + 48'h0000_2000_0000;
      r    = prod[47:30];
      if (r > 18'd65535) r = 18'd65535;
      to_pos = neg ? 17'(18'd0 - r) : r[16:0];
   endfunction

   // register port
   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      ring_cnt_in = ring_cnt_ff;
      seg_cnt_in  = seg_cnt_ff;
      radius_in   = radius_ff;
      if (wr_en) begin
         unique case (paddr[3:2])
            uvs_pkg::REG_RING:    ring_cnt_in = pwdata[GRID_BITS-1:0];
            uvs_pkg::REG_SEGMENT: seg_cnt_in  = pwdata[GRID_BITS-1:0];
            uvs_pkg::REG_RADIUS:  radius_in   = pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         uvs_pkg::REG_RING:    prdata = 32'(ring_cnt_ff);
         uvs_pkg::REG_SEGMENT: prdata = 32'(seg_cnt_ff);
         uvs_pkg::REG_RADIUS:  prdata = {16'd0, radius_ff};
         default:              prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_cnt_ff <= GRID_BITS'(16);
         seg_cnt_ff  <= GRID_BITS'(32);
         radius_ff   <= 16'd256;
      end else begin
         ring_cnt_ff <= ring_cnt_in;
         seg_cnt_ff  <= seg_cnt_in;
         radius_ff   <= radius_in;
      end
   end

   // flow control
   assign adv       = !vld_ff[uvs_pkg::PIPE_LAT-1] || rsp_ready;
   assign req_ready = adv;
   assign vld_in    = {vld_ff[uvs_pkg::PIPE_LAT-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // clamp and integer quotient bit
   always_comb begin
      rings    = (ring_cnt_ff == '0) ? GRID_BITS'(1) : ring_cnt_ff;
      segs     = (seg_cnt_ff == '0) ? GRID_BITS'(1) : seg_cnt_ff;
      ring_c   = (req_ring_index > rings) ? rings : req_ring_index;
      seg_c    = (req_segment_index > segs) ? segs : req_segment_index;
      rrem[0]  = (ring_c == rings) ? '0 : ring_c;
      rquot[0] = QW'(ring_c == rings);
      srem[0]  = (seg_c == segs) ? '0 : seg_c;
      squot[0] = QW'(seg_c == segs);
   end

   for (genvar i = 0; i < NC; i++) begin : g_cells
      uvs_div_cell #(.GRID_BITS(GRID_BITS)) u_ring_cell (
         .clock(clock), .adv(adv), .divisor(rings),
         .rem_in(rrem[i]), .quot_in(rquot[i]),
         .rem_out(rrem[i+1]), .quot_out(rquot[i+1])
      );
      uvs_div_cell #(.GRID_BITS(GRID_BITS)) u_seg_cell (
         .clock(clock), .adv(adv), .divisor(segs),
         .rem_in(srem[i]), .quot_in(squot[i]),
         .rem_out(srem[i+1]), .quot_out(squot[i+1])
      );
   end

   // angles and texture coordinates, rounded from the quotients
   always_comb begin
      s_sum   = {1'b0, squot[NC]} + (QW+1)'(1);
      theta   = s_sum[uvs_pkg::PHASE_W:1];
      r_sum   = {1'b0, rquot[NC][QW-1:1]} + QW'(1);
      phi     = r_sum[uvs_pkg::PHASE_W:1];
      u_sum   = {1'b0, squot[NC][QW-1:8]} + 19'd1;
      tex_u   = u_sum[17:1];
      v_sum   = {1'b0, rquot[NC][QW-1:8]} + 19'd1;
      tex_v   = 17'd65536 - v_sum[17:1];
      theta_c = theta + 24'h40_0000;
      phi_c   = phi + 24'h40_0000;
   end

   uvs_sine u_sin_phi   (.clock(clock), .adv(adv), .phase(phi),     .result(sp));
   uvs_sine u_cos_phi   (.clock(clock), .adv(adv), .phase(phi_c),   .result(cp));
   uvs_sine u_sin_theta (.clock(clock), .adv(adv), .phase(theta),   .result(st));
   uvs_sine u_cos_theta (.clock(clock), .adv(adv), .phase(theta_c), .result(ct));

   always_ff @(posedge clock) begin
      if (adv) begin
         texu_ff[0] <= tex_u;
         texv_ff[0] <= tex_v;
         for (int k = 1; k < uvs_pkg::TEX_DLY; k++) begin
            texu_ff[k] <= texu_ff[k-1];
            texv_ff[k] <= texv_ff[k-1];
         end
      end
   end

   // normal products
   assign nx_prod = (sp.mag * ct.mag) + 62'h2000_0000;
   assign nz_prod = (sp.mag * st.mag) + 62'h2000_0000;

   always_ff @(posedge clock) begin
      if (adv) begin
         nx_ff  <= nx_prod[60:30];
         nz_ff  <= nz_prod[60:30];
         nxn_ff <= sp.neg ^ ct.neg;
         nzn_ff <= sp.neg ^ st.neg;
         cp_ff  <= cp;
         st_ff  <= st;
         ct_ff  <= ct;
      end
   end

   // output stage
   always_comb begin
      px_in = to_pos(nxn_ff, nx_ff, radius_ff);
      py_in = to_pos(cp_ff.neg, cp_ff.mag, radius_ff);
      pz_in = to_pos(nzn_ff, nz_ff, radius_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         px_ff  <= px_in;
         py_ff  <= py_in;
         pz_ff  <= pz_in;
         tu_ff  <= texu_ff[uvs_pkg::TEX_DLY-1];
         tv_ff  <= texv_ff[uvs_pkg::TEX_DLY-1];
         nxq_ff <= uvs_pkg::to_q15(nxn_ff, nx_ff);
         nyq_ff <= uvs_pkg::to_q15(cp_ff.neg, cp_ff.mag);
         nzq_ff <= uvs_pkg::to_q15(nzn_ff, nz_ff);
         tx_ff  <= uvs_pkg::to_q15(!st_ff.neg, st_ff.mag);
         tz_ff  <= uvs_pkg::to_q15(ct_ff.neg, ct_ff.mag);
      end
   end

   assign rsp_valid  = vld_ff[uvs_pkg::PIPE_LAT-1];
   assign rsp_pos_x  = px_ff;
   assign rsp_pos_y  = py_ff;
   assign rsp_pos_z  = pz_ff;
   assign rsp_tex_u  = tu_ff;
   assign rsp_tex_v  = tv_ff;
   assign rsp_norm_x = nxq_ff;
   assign rsp_norm_y = nyq_ff;
   assign rsp_norm_z = nzq_ff;
   assign rsp_tan_x  = tx_ff;
   assign rsp_tan_z  = tz_ff;

   `ASSERT_IMPLY(a_tex_u_range, clock, reset, rsp_valid, rsp_tex_u <= 17'd65536)
   `ASSERT_IMPLY(a_tex_v_range, clock, reset, rsp_valid, rsp_tex_v <= 17'd65536)
   `ASSERT_IMPLY(a_stall_blocks_req, clock, reset, rsp_valid && !rsp_ready, !req_ready)
endmodule

// File: rtl/core/uvs_div_cell.sv
// One restoring-division cell: produces one quotient bit per stage
module uvs_div_cell #(
   parameter int GRID_BITS = 8
) (
   input  logic                        clock,
   input  logic                        adv,
   input  logic [GRID_BITS-1:0]        divisor,
   input  logic [GRID_BITS-1:0]        rem_in,
   input  logic [uvs_pkg::QUOT_W-1:0]  quot_in,
   output logic [GRID_BITS-1:0]        rem_out,
   output logic [uvs_pkg::QUOT_W-1:0]  quot_out
);
   logic [GRID_BITS:0]          dbl;
   logic                        qbit;
   logic [GRID_BITS:0]          diff;
   logic [GRID_BITS-1:0]        rem_in_w;
   logic [GRID_BITS-1:0]        rem_ff;
   logic [uvs_pkg::QUOT_W-1:0]  quot_ff;

   always_comb begin
      dbl      = {rem_in, 1'b0};
      qbit     = dbl >= {1'b0, divisor};
      diff     = dbl - {1'b0, divisor};
      rem_in_w = qbit ? diff[GRID_BITS-1:0] : dbl[GRID_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff  <= rem_in_w;
         quot_ff <= {quot_in[uvs_pkg::QUOT_W-2:0], qbit};
      end
   end

   assign rem_out  = rem_ff;
   assign quot_out = quot_ff;
endmodule

// File: rtl/core/uvs_sine.sv
// Pipelined sine of a 24-bit turn fraction, odd polynomial by Horner
module uvs_sine (
   input  logic                          clock,
   input  logic                          adv,
   input  logic [uvs_pkg::PHASE_W-1:0]   phase,
   output uvs_pkg::sine_type             result
);
   logic [29:0]       fr;
   uvs_pkg::q30_type  t_in;
   uvs_pkg::q30_type  t0_ff;
   logic              n0_ff;
   logic [61:0]       sq_prod;
   uvs_pkg::q30_type  t2_ff;
   uvs_pkg::q30_type  t1_ff;
   logic              n1_ff;
   uvs_pkg::q30_type  qh_ff [5];
   uvs_pkg::q30_type  th_ff [5];
   uvs_pkg::q30_type  t2h_ff [5];
   logic              nh_ff [5];
   logic [61:0]       fin_prod;
   uvs_pkg::q30_type  s_in;
   uvs_pkg::sine_type res_ff;

   always_comb begin
      fr   = {phase[21:0], 8'd0};
      t_in = phase[22] ? (uvs_pkg::Q30_ONE - {1'b0, fr}) : {1'b0, fr};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t0_ff <= t_in;
         n0_ff <= phase[23];
      end
   end

   assign sq_prod = t0_ff * t0_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         t2_ff <= sq_prod[60:30];
         t1_ff <= t0_ff;
         n1_ff <= n0_ff;
      end
   end

   for (genvar k = 0; k < 5; k++) begin : g_horner
      uvs_pkg::q30_type q_src;
      uvs_pkg::q30_type t2_src;
      uvs_pkg::q30_type t_src;
      logic             n_src;
      logic [61:0]      prod;
      if (k == 0) begin : g_first
         assign q_src  = uvs_pkg::SC11;
         assign t2_src = t2_ff;
         assign t_src  = t1_ff;
         assign n_src  = n1_ff;
      end else begin : g_rest
         assign q_src  = qh_ff[k-1];
         assign t2_src = t2h_ff[k-1];
         assign t_src  = th_ff[k-1];
         assign n_src  = nh_ff[k-1];
      end
      assign prod = q_src * t2_src;
      always_ff @(posedge clock) begin
         if (adv) begin
            qh_ff[k]  <= uvs_pkg::HORNER_COEF[k] - prod[60:30];
            t2h_ff[k] <= t2_src;
            th_ff[k]  <= t_src;
            nh_ff[k]  <= n_src;
         end
      end
   end

   always_comb begin
      fin_prod = qh_ff[4] * th_ff[4];
      s_in     = (fin_prod[61:30] > {1'b0, uvs_pkg::Q30_ONE}) ? uvs_pkg::Q30_ONE
                                                              : fin_prod[60:30];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         res_ff.mag <= s_in;
         res_ff.neg <= nh_ff[4];
      end
   end

   assign result = res_ff;
endmodule
